/* sv/mean_median_mode_stats_macros.svh */
// Assertion helpers used by the checker file.
`ifndef MEAN_MEDIAN_MODE_STATS_MACROS_SVH
`define MEAN_MEDIAN_MODE_STATS_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MMMS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define MMMS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Next-cycle implication.
`define MMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mmms_pkg.sv */
package mmms_pkg;

    localparam int SCORE_W = 16;
    localparam int AVG_W   = 24;
    localparam int CNT_W   = 9;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic busy;
    } div_stat_t;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_LATCH = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_DIVW  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

endpackage

/* sv/mmms_ram.sv */
module mmms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/mmms_div.sv */
module mmms_div #(
    parameter int DW = 32,
    parameter int VW = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [VW-1:0]       divisor,
    output logic [DW-1:0]       quotient,
    output mmms_pkg::div_stat_t stat
);

    import mmms_pkg::*;

    localparam int KW = $clog2(DW + 1);

    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   rem_sh;

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[VW-1:0], num_reg[DW-1]};
        if (start)
        begin
            num_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = KW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            num_next = {num_reg[DW-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == KW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;

endmodule

/* sv/mean_median_mode_stats.sv */
// Scores load at one per cycle while s_tready is high in S_LOAD; after the set's last
// transfer the result waits for the single compare unit, which scans the score RAM
// once per candidate, and for the mean divider to finish. Throughput: one set at a
// time, no input taken meanwhile.
// Reset: rst_n is asynchronous, active low; it clears the set and the sequencer.
module mean_median_mode_stats #(
    parameter int MAX_SCORES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] score
    input  logic        s_tlast,     // last score of the set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [mmms_pkg::OUT_DATA_W-1:0] m_tdata,
    // [23:0] average_q8, [39:24] median, [55:40] mode, [64:56] count, rest zero
    output logic        m_tuser      // overflow
);

    import mmms_pkg::*;

    localparam int AW = $clog2(MAX_SCORES);
    localparam int CW = $clog2(MAX_SCORES + 1);
    localparam int SW = $clog2(MAX_SCORES * 65535 + 1);
    localparam int DW = SW + 8;

    state_t state_reg, state_next;

    // set accumulation
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          drop_reg, drop_next;

    // rank scan
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [SCORE_W-1:0] x_reg, x_next;
    logic [CW-1:0]      lt_reg, lt_next;
    logic [CW-1:0]      eq_reg, eq_next;
    logic [SCORE_W-1:0] lo_reg, lo_next;
    logic [SCORE_W-1:0] hi_reg, hi_next;
    logic [SCORE_W-1:0] best_reg, best_next;
    logic [CW-1:0]      beq_reg, beq_next;

    // result
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [SCORE_W-1:0] med_reg, med_next;
    logic [SCORE_W-1:0] mode_reg, mode_next;
    logic [CNT_W-1:0]   ocnt_reg, ocnt_next;
    logic               oflow_reg, oflow_next;

    logic               s_xfer, m_xfer;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [SCORE_W-1:0] ram_rdata;
    logic               div_start;
    logic [DW-1:0]      div_q;
    div_stat_t          div_stat;

    logic [AW-1:0]      nm1;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      tgt_lo;
    logic [CW:0]        rank_end;
    logic               hit_lo, hit_hi;

    assign s_tready = (state_reg == S_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_xfer   = m_tvalid && m_tready;

    assign ram_we    = s_xfer && (cnt_reg < CW'(MAX_SCORES));
    assign div_start = s_xfer && s_tlast;

    mmms_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_SCORES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // mean: (sum << 8) / n, one quotient bit per cycle
    mmms_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_next, 8'b0}),
        .divisor  (cnt_next),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // rank window of the current candidate against the median positions
    assign nm1      = AW'(cnt_reg - 1'b1);
    assign mid      = cnt_reg >> 1;
    assign tgt_lo   = cnt_reg[0] ? mid : mid - 1'b1;
    assign rank_end = {1'b0, lt_reg} + {1'b0, eq_reg};
    assign hit_lo   = (lt_reg <= tgt_lo) && ({1'b0, tgt_lo} < rank_end);
    assign hit_hi   = (lt_reg <= mid) && ({1'b0, mid} < rank_end);

    always_comb
    begin
        case (state_reg)
            S_FETCH: ram_raddr = i_reg;
            S_LATCH: ram_raddr = '0;
            S_SCAN:  ram_raddr = j_reg + 1'b1;
            default: ram_raddr = i_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        best_next  = best_reg;
        beq_next   = beq_reg;
        avg_next   = avg_reg;
        med_next   = med_reg;
        mode_next  = mode_reg;
        ocnt_next  = ocnt_reg;
        oflow_next = oflow_reg;

        // store or drop the incoming score; the divider sees these next values
        if (s_xfer)
        begin
            if (cnt_reg < CW'(MAX_SCORES))
            begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_reg + SW'(s_tdata);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (s_xfer && s_tlast)
                begin
                    i_next     = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                // candidate arrives; the scan starts at entry 0
                x_next     = ram_rdata;
                j_next     = '0;
                lt_next    = '0;
                eq_next    = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (ram_rdata < x_reg)
                begin
                    lt_next = lt_reg + 1'b1;
                end
                if (ram_rdata == x_reg)
                begin
                    eq_next = eq_reg + 1'b1;
                end
                if (j_reg == nm1)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_EVAL:
            begin
                if (hit_lo)
                begin
                    lo_next = x_reg;
                end
                if (hit_hi)
                begin
                    hi_next = x_reg;
                end
                // most equal entries wins; ties go to the smaller score
                if ((i_reg == '0) || (eq_reg > beq_reg) ||
                    ((eq_reg == beq_reg) && (x_reg < best_reg)))
                begin
                    best_next = x_reg;
                    beq_next  = eq_reg;
                end
                if (i_reg == nm1)
                begin
                    state_next = S_DIVW;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DIVW:
            begin
                if (!div_stat.busy)
                begin
                    avg_next   = AVG_W'(div_q);
                    med_next   = SCORE_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
                    mode_next  = best_reg;
                    ocnt_next  = CNT_W'(cnt_reg);
                    oflow_next = drop_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold the result until taken, then open a new set
                if (m_xfer)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    drop_next  = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        x_reg     <= x_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        best_reg  <= best_next;
        beq_reg   <= beq_next;
        avg_reg   <= avg_next;
        med_reg   <= med_next;
        mode_reg  <= mode_next;
        ocnt_reg  <= ocnt_next;
        oflow_reg <= oflow_next;
    end

    assign m_tdata = {(OUT_DATA_W - 65)'(0), ocnt_reg, mode_reg, med_reg, avg_reg};
    assign m_tuser = oflow_reg;

endmodule

/* sv/mmms_checker.sv */
`include "mean_median_mode_stats_macros.svh"

module mmms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [mmms_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic        m_tuser
);

    `MMMS_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input open while a result waits")
    `MMMS_ASSERT_NEXT(a_close_set, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last")
    `MMMS_ASSERT_NEXT(a_reopen, m_tvalid && m_tready, s_tready && !m_tvalid, "no reopen after result")
    `MMMS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind mean_median_mode_stats mmms_checker u_mmms_checker (.*);
